[rtl/kcd_pkg.sv]
// kcd_pkg: shared constants and types for the keyboard chord detector
// set-1 scancodes, action codes and counter width; no dependencies
`timescale 1ns / 1ps

package kcd_pkg;

  // width of the saturating near-miss counter (1 to 32)
  localparam int MISS_COUNT_WIDTH = 16;
  // width of the near_miss_count result field
  localparam int NEAR_MISS_WIDTH = 16;

  // set-1 scancodes of interest
  localparam logic [7:0] SC_PREFIX      = 8'hE0;
  localparam logic [7:0] SC_RCTRL_MAKE  = 8'h1D;
  localparam logic [7:0] SC_RCTRL_BREAK = 8'h9D;
  localparam logic [7:0] SC_RALT_MAKE   = 8'h38;
  localparam logic [7:0] SC_RALT_BREAK  = 8'hB8;
  localparam logic [7:0] SC_LEFT_MAKE   = 8'h4B;
  localparam logic [7:0] SC_RIGHT_MAKE  = 8'h4D;
  localparam logic [7:0] SC_PRT_FIRST   = 8'h2A;
  localparam logic [7:0] SC_PRT_SECOND  = 8'h37;
  localparam logic [7:0] SC_SYSRQ_MAKE  = 8'h54;
  localparam logic [7:0] SC_SYSRQ_BREAK = 8'hD4;
  localparam logic [7:0] SC_D_MAKE      = 8'h20;
  localparam logic [7:0] SC_ESC_MAKE    = 8'h01;
  localparam logic [7:0] SC_DIGIT1_MAKE = 8'h02;
  localparam logic [7:0] SC_DIGIT9_MAKE = 8'h0A;

  // chord actions
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PREV   = 3'd1,
    ACT_NEXT   = 3'd2,
    ACT_SHOT   = 3'd3,
    ACT_TOGGLE = 3'd4,
    ACT_RETURN = 3'd5,
    ACT_JUMP   = 3'd6
  } action_t;

endpackage

[rtl/keyboard_chord_detector.sv]
// keyboard_chord_detector: decodes a set-1 scancode stream into chord actions
// input register, combinational decode and flag update, result register; uses kcd_pkg
`timescale 1ns / 1ps
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  input    | in_valid, in_ready, scancode             | in
//  result   | out_valid, out_ready, action, target_vm, | out
//           | near_miss_count                          |
//
// one request accepted per cycle while the result is not stalled, one result per request
// an accepted request passes through the input register and then the result register
// the decode and flag update run combinationally between the two registers
// a stalled result holds; one more request is still taken into the input register
// rst is synchronous and clears flags, counter and both valid bits

module keyboard_chord_detector (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            scancode,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            action,
  output logic [3:0]                            target_vm,
  output logic [kcd_pkg::NEAR_MISS_WIDTH-1:0]   near_miss_count
);
  import kcd_pkg::*;

  // input register
  logic       in_reg_valid;
  logic [7:0] in_code;

  // decoder state
  logic                        extended_pending;
  logic                        right_ctrl_down;
  logic                        right_alt_down;
  logic                        print_half_seen;
  logic [MISS_COUNT_WIDTH-1:0] miss_counter;

  logic                        extended_pending_next;
  logic                        right_ctrl_down_next;
  logic                        right_alt_down_next;
  logic                        print_half_seen_next;
  logic [MISS_COUNT_WIDTH-1:0] miss_counter_next;
  action_t                     action_next;
  logic [3:0]                  target_vm_next;

  logic       chord;
  logic       miss;
  logic       advance;
  logic [3:0] vm_wide;

  // result register
  action_t                     action_reg;
  logic [3:0]                  vm_reg;
  logic [MISS_COUNT_WIDTH-1:0] count_reg;

  // handshake: move the input register forward when the result register is free
  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_code <= scancode;
    end
  end

  // digit to vm number: 0x02..0x0A maps to 1..9
  assign vm_wide = in_code[3:0] - 4'd1;
  assign chord   = right_ctrl_down && right_alt_down;

  // decode and next flags
  always_comb begin
    extended_pending_next = 1'b0;
    right_ctrl_down_next  = right_ctrl_down;
    right_alt_down_next   = right_alt_down;
    print_half_seen_next  = 1'b0;
    action_next           = ACT_NONE;
    target_vm_next        = 4'd0;
    miss                  = 1'b0;

    if (in_code == SC_PREFIX) begin
      // prefix arms the next byte, partial print match is kept
      extended_pending_next = 1'b1;
      print_half_seen_next  = print_half_seen;
    end else if (extended_pending) begin
      print_half_seen_next = print_half_seen;
      case (in_code)
        SC_RCTRL_MAKE:  right_ctrl_down_next = 1'b1;
        SC_RCTRL_BREAK: right_ctrl_down_next = 1'b0;
        SC_RALT_MAKE:   right_alt_down_next  = 1'b1;
        SC_RALT_BREAK:  right_alt_down_next  = 1'b0;
        // arrow keys keep the partial print match
        SC_LEFT_MAKE: begin
          if (chord) action_next = ACT_PREV;
        end
        SC_RIGHT_MAKE: begin
          if (chord) action_next = ACT_NEXT;
        end
        SC_PRT_FIRST:   print_half_seen_next = 1'b1;
        SC_PRT_SECOND: begin
          print_half_seen_next = 1'b0;
          if (print_half_seen) begin
            if (chord) action_next = ACT_SHOT;
            else miss = 1'b1;
          end
        end
        default:        print_half_seen_next = 1'b0;
      endcase
    end else begin
      // plain byte
      if (in_code == SC_D_MAKE) begin
        if (chord) action_next = ACT_TOGGLE;
      end else if (in_code == SC_SYSRQ_MAKE) begin
        if (chord) action_next = ACT_SHOT;
        else miss = 1'b1;
      end else if (in_code == SC_ESC_MAKE) begin
        if (chord) action_next = ACT_RETURN;
      end else if (chord && (in_code inside {[SC_DIGIT1_MAKE:SC_DIGIT9_MAKE]})) begin
        action_next    = ACT_JUMP;
        target_vm_next = vm_wide;
      end
    end
  end

  // saturating near-miss counter
  always_comb begin
    miss_counter_next = miss_counter;
    if (miss && (miss_counter != '1)) begin
      miss_counter_next = miss_counter + MISS_COUNT_WIDTH'(1);
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      extended_pending <= 1'b0;
      right_ctrl_down  <= 1'b0;
      right_alt_down   <= 1'b0;
      print_half_seen  <= 1'b0;
      miss_counter     <= '0;
    end else if (advance) begin
      extended_pending <= extended_pending_next;
      right_ctrl_down  <= right_ctrl_down_next;
      right_alt_down   <= right_alt_down_next;
      print_half_seen  <= print_half_seen_next;
      miss_counter     <= miss_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= in_reg_valid;
    end
    if (advance) begin
      action_reg <= action_next;
      vm_reg     <= target_vm_next;
      count_reg  <= miss_counter_next;
    end
  end

  assign action          = action_reg;
  assign target_vm       = vm_reg;
  assign near_miss_count = NEAR_MISS_WIDTH'(count_reg);

endmodule

[rtl/kcd_checker.sv]
// kcd_checker: port-level assertions for keyboard_chord_detector
// bound to the top level below; uses kcd_pkg
`timescale 1ns / 1ps

module kcd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [2:0]                          action,
  input logic [3:0]                          target_vm,
  input logic [kcd_pkg::NEAR_MISS_WIDTH-1:0] near_miss_count
);
  import kcd_pkg::*;

  // reset empties the result side
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // reset leaves the input side open
  assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready right after reset");

  // vm number present exactly for a jump
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((action == ACT_JUMP) == (target_vm != 4'd0)))
    else $error("target_vm does not match action");

  // jump targets stay within 1..9
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == ACT_JUMP) |-> (target_vm <= 4'd9))
    else $error("target_vm out of range");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(action) && $stable(target_vm)
      && $stable(near_miss_count))
    else $error("stalled result changed");

endmodule

bind keyboard_chord_detector kcd_checker u_kcd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .action          (action),
  .target_vm       (target_vm),
  .near_miss_count (near_miss_count)
);
